/* rtl/gfr_pkg.sv */
// Shared types, widths and helpers for the free-run gap finder.
// No dependencies; every other file imports this package.
package gfr_pkg;

    // Frame and list sizing
    localparam int MAX_COLUMNS = 1024;
    localparam int TOP_N_MAX   = 8;

    // Field widths
    localparam int COL_W      = $clog2(MAX_COLUMNS);
    localparam int LEN_W      = $clog2(MAX_COLUMNS + 1);
    localparam int CNT_W      = $clog2(TOP_N_MAX + 1);
    localparam int RANK_W     = 3;
    localparam int DEPTH_W    = 20;
    localparam int FRAC_W     = 4;
    localparam int THR_W      = 16;
    localparam int TOPC_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(2999);
    localparam logic [TOPC_W-1:0] TOP_COUNT_RESET = TOPC_W'(2);

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_THRESHOLD = 2'd0,
        REG_TOP_COUNT       = 2'd1
    } cfg_reg_t;

    // One entry of the sorted gap list
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] gap_start;
        logic [COL_W-1:0] gap_end;
    } gap_t;

    // A closed run offered to the list
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] gap_start;
        logic [COL_W-1:0] gap_end;
        logic [LEN_W-1:0] len;
    } ins_t;

    // end - start + 1
    function automatic logic [LEN_W-1:0] gap_len(input logic [COL_W-1:0] s,
                                                 input logic [COL_W-1:0] e);
        gap_len = {1'b0, e} - {1'b0, s} + LEN_W'(1);
    endfunction

endpackage

/* rtl/gfr_col_if.sv */
// Column input channel: valid/ready plus one column beat.
// Depends on gfr_pkg.
interface gfr_col_if import gfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_value;
    logic               last_column;

    modport source (output valid, depth_value, last_column, input ready);
    modport sink   (input valid, depth_value, last_column, output ready);
endinterface

/* rtl/gfr_gap_if.sv */
// Result channel: valid/ready plus one gap beat.
// Depends on gfr_pkg.
interface gfr_gap_if import gfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [RANK_W-1:0] rank;
    logic [COL_W-1:0]  gap_start;
    logic [COL_W-1:0]  gap_end;
    logic [LEN_W-1:0]  gap_length;
    logic              last_result;

    modport source (output valid, found, rank, gap_start, gap_end, gap_length,
                    last_result, input ready);
    modport sink   (input valid, found, rank, gap_start, gap_end, gap_length,
                    last_result, output ready);
endinterface

/* rtl/gfr_cfg_if.sv */
// Configuration write channel: valid/ready, register index and data.
// Depends on gfr_pkg.
interface gfr_cfg_if import gfr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/free_run_gap_finder_top_n.sv */
// A frame's first result is valid in the cycle after its last column beat.
// Throughput: one column per cycle; up to TOP_N_MAX results, one per ready cycle.
// A last column waits only while the previous frame's results are still draining.
// Insertion rate is set by the list cells, which all compare in the same cycle.
// Reset (rst_n low, async): list, run state and result chain clear;
// depth_threshold returns to 2999 and top_count to 2.
module free_run_gap_finder_top_n import gfr_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    gfr_col_if.sink        col_in,
    gfr_gap_if.source      gap_out,
    gfr_cfg_if.sink        cfg
);

    logic [THR_W-1:0]  threshold_reg;
    logic [TOPC_W-1:0] top_count_reg;
    logic              busy_reg, busy_next;
    logic [RANK_W-1:0] rank_reg, rank_next;

    logic              col_acc;
    logic              out_acc;
    logic              snap_load;
    logic              snap_shift;
    logic [CNT_W-1:0]  want;
    logic              frame_end;
    ins_t              ins;

    gap_t              gap_q     [TOP_N_MAX];
    gap_t              prev_gap  [TOP_N_MAX];
    gap_t              snap_q    [TOP_N_MAX];
    gap_t              snap_in   [TOP_N_MAX];
    logic [TOP_N_MAX-1:0] keep;
    logic [TOP_N_MAX-1:0] prev_keep;
    logic [TOP_N_MAX-1:0] snap_en;
    logic [TOP_N_MAX-1:0] list_valid;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            top_count_reg <= TOP_COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_DEPTH_THRESHOLD: threshold_reg <= cfg.data[THR_W-1:0];
                REG_TOP_COUNT:       top_count_reg <= cfg.data[TOPC_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshakes
    assign col_in.ready = !(busy_reg && col_in.last_column);
    assign col_acc      = col_in.valid && col_in.ready;
    assign out_acc      = gap_out.valid && gap_out.ready;
    assign snap_load    = frame_end;
    assign snap_shift   = out_acc && !gap_out.last_result;

    // Clamp of top_count to 1..TOP_N_MAX
    always_comb
    begin
        if (top_count_reg == '0)
            want = CNT_W'(1);
        else if (32'(top_count_reg) > 32'(TOP_N_MAX))
            want = CNT_W'(TOP_N_MAX);
        else
            want = CNT_W'(top_count_reg);
    end

    gfr_column u_column (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (col_acc),
        .depth_value (col_in.depth_value),
        .last_column (col_in.last_column),
        .threshold   (threshold_reg),
        .ins         (ins),
        .frame_end   (frame_end)
    );

    // Row of list cells
    for (genvar k = 0; k < TOP_N_MAX; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign prev_keep[k] = 1'b1;
            assign prev_gap[k]  = '0;
        end
        else
        begin : g_body
            assign prev_keep[k] = keep[k-1];
            assign prev_gap[k]  = gap_q[k-1];
        end

        if (k == TOP_N_MAX - 1)
        begin : g_tail
            assign snap_in[k] = '0;
        end
        else
        begin : g_link
            assign snap_in[k] = snap_q[k+1];
        end

        assign snap_en[k]    = k < 32'(want);
        assign list_valid[k] = gap_q[k].valid;

        gfr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ins        (ins),
            .frame_end  (frame_end),
            .prev_keep  (prev_keep[k]),
            .prev_gap   (prev_gap[k]),
            .keep       (keep[k]),
            .gap_q      (gap_q[k]),
            .snap_load  (snap_load),
            .snap_en    (snap_en[k]),
            .snap_shift (snap_shift),
            .snap_prev  (snap_in[k]),
            .snap_q     (snap_q[k])
        );
    end

    // Result sequencing
    always_comb
    begin
        busy_next = busy_reg;
        rank_next = rank_reg;
        if (snap_load)
        begin
            busy_next = 1'b1;
            rank_next = '0;
        end
        else if (out_acc)
        begin
            if (gap_out.last_result)
                busy_next = 1'b0;
            else
                rank_next = rank_reg + RANK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rank_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            rank_reg <= rank_next;
        end
    end

    // Result beat from the head of the chain
    always_comb
    begin
        gap_out.valid       = busy_reg;
        gap_out.found       = snap_q[0].valid;
        gap_out.rank        = snap_q[0].valid ? rank_reg : '0;
        gap_out.gap_start   = snap_q[0].valid ? snap_q[0].gap_start : '0;
        gap_out.gap_end     = snap_q[0].valid ? snap_q[0].gap_end : '0;
        gap_out.gap_length  = snap_q[0].valid
                            ? gap_len(snap_q[0].gap_start, snap_q[0].gap_end) : '0;
        gap_out.last_result = !snap_in[0].valid;
    end

    a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
        gap_out.valid && !gap_out.found |-> gap_out.last_result)
        else $error("empty frame result not marked last");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        col_acc && col_in.last_column |=> gap_out.valid)
        else $error("no result after last column");
    a_list_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((list_valid >> 1) & ~list_valid) == '0)
        else $error("gap list has a hole");
    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        gap_out.valid && gap_out.found |-> gap_out.gap_length >= LEN_W'(2))
        else $error("reported gap shorter than two columns");

endmodule

/* rtl/gfr_column.sv */
// Column tracker: free test, run tracking and closing of runs.
// Depends on gfr_pkg.
module gfr_column import gfr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               acc,
    input  logic [DEPTH_W-1:0] depth_value,
    input  logic               last_column,
    input  logic [THR_W-1:0]   threshold,
    output ins_t               ins,
    output logic               frame_end
);

    logic [COL_W-1:0] column_index_reg, column_index_next;
    logic             in_run_reg, in_run_next;
    logic [COL_W-1:0] run_start_reg, run_start_next;
    logic             frame_full_reg, frame_full_next;

    logic             is_free;
    logic             close_en;
    logic [COL_W-1:0] close_e;
    logic [COL_W-1:0] start_eff;

    // Free column: frame not full, above zero and at most threshold (scaled to 4 fraction bits)
    assign is_free = !frame_full_reg && (depth_value != '0) &&
                     (depth_value <= {threshold, FRAC_W'(0)});

    assign start_eff = in_run_reg ? run_start_reg : column_index_reg;
    assign frame_end = acc && last_column;

    // Run close decision and next state
    always_comb
    begin
        close_en          = 1'b0;
        close_e           = column_index_reg;
        column_index_next = column_index_reg;
        in_run_next       = in_run_reg;
        run_start_next    = run_start_reg;
        frame_full_next   = frame_full_reg;

        if (is_free)
        begin
            // open run ends here on the last column
            close_en = last_column;
        end
        else if (in_run_reg)
        begin
            close_en = 1'b1;
            close_e  = frame_full_reg ? column_index_reg
                                      : column_index_reg - COL_W'(1);
        end

        if (acc)
        begin
            if (last_column)
            begin
                column_index_next = '0;
                in_run_next       = 1'b0;
                run_start_next    = '0;
                frame_full_next   = 1'b0;
            end
            else
            begin
                in_run_next    = is_free;
                run_start_next = (is_free && !in_run_reg) ? column_index_reg
                                                          : run_start_reg;
                if (column_index_reg == COL_W'(MAX_COLUMNS - 1))
                    frame_full_next = 1'b1;
                else
                    column_index_next = column_index_reg + COL_W'(1);
            end
        end
    end

    // Runs of one column are dropped
    always_comb
    begin
        ins.en        = acc && close_en && (close_e > start_eff);
        ins.gap_start = start_eff;
        ins.gap_end   = close_e;
        ins.len       = gap_len(start_eff, close_e);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_index_reg <= '0;
            in_run_reg       <= 1'b0;
            run_start_reg    <= '0;
            frame_full_reg   <= 1'b0;
        end
        else
        begin
            column_index_reg <= column_index_next;
            in_run_reg       <= in_run_next;
            run_start_reg    <= run_start_next;
            frame_full_reg   <= frame_full_next;
        end
    end

    a_index_held_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        frame_full_reg |-> column_index_reg == COL_W'(MAX_COLUMNS - 1))
        else $error("column index moved after frame full");
    a_no_free_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        frame_full_reg && acc |=> !in_run_reg)
        else $error("run still open after frame full");
    a_ins_len_two: assert property (@(posedge clk) disable iff (!rst_n)
        ins.en |-> ins.len >= LEN_W'(2))
        else $error("short run offered to list");

endmodule

/* rtl/gfr_cell.sv */
// One cell of the sorted gap list plus its stage of the result shift chain.
// Depends on gfr_pkg.
module gfr_cell import gfr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  ins_t ins,
    input  logic frame_end,
    input  logic prev_keep,
    input  gap_t prev_gap,
    output logic keep,
    output gap_t gap_q,
    input  logic snap_load,
    input  logic snap_en,
    input  logic snap_shift,
    input  gap_t snap_prev,
    output gap_t snap_q
);

    gap_t gap_reg, gap_next;
    gap_t snap_reg;
    gap_t new_gap;

    // Entry stays put when at least as long as the new run (ties keep order)
    assign keep = gap_reg.valid &&
                  (gap_len(gap_reg.gap_start, gap_reg.gap_end) >= ins.len);

    always_comb
    begin
        new_gap.valid     = 1'b1;
        new_gap.gap_start = ins.gap_start;
        new_gap.gap_end   = ins.gap_end;
        gap_next          = gap_reg;
        if (ins.en && !keep)
            gap_next = prev_keep ? new_gap : prev_gap;
    end

    // List entry, cleared at the end of each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_reg <= '0;
        else if (frame_end)
            gap_reg <= '0;
        else
            gap_reg <= gap_next;
    end

    // Result chain: load the final list, then shift toward cell 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_reg <= '0;
        else if (snap_load)
            snap_reg <= snap_en ? gap_next : '0;
        else if (snap_shift)
            snap_reg <= snap_prev;
    end

    assign gap_q  = gap_reg;
    assign snap_q = snap_reg;

    a_valid_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        gap_reg.valid |-> gap_reg.gap_end > gap_reg.gap_start)
        else $error("list entry shorter than two columns");
    a_load_shift_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(snap_load && snap_shift))
        else $error("result chain loaded while shifting");
    a_cleared_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> !gap_reg.valid)
        else $error("list entry survived end of frame");

endmodule

/* dv/tb_top.sv */
// Self-checking bench for free_run_gap_finder_top_n: directed frames from a table, then
// random frames under several threshold / top-count settings, checked against a gap list model.
// Depends on gfr_pkg, the channel interfaces and the RTL top.
module tb_top import gfr_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    // Index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic [DEPTH_W-1:0]   DEPTH_MAX    = '1;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 150;
    localparam int IDLE_PCT     = 11;

    // One result beat as seen on the gap channel
    typedef struct packed {
        logic              found;
        logic [RANK_W-1:0] rank;
        logic [COL_W-1:0]  gap_start;
        logic [COL_W-1:0]  gap_end;
        logic [LEN_W-1:0]  gap_length;
        logic              last_result;
    } gap_beat_t;

    localparam gap_beat_t NO_GAP = '{1'b0, '0, '0, '0, '0, 1'b1};

    // Directed stimulus row: a column repeated reps times, optional hand-written result
    typedef struct {
        logic [DEPTH_W-1:0] depth;
        bit                 last;
        int                 reps;
        bit                 typed;
        gap_beat_t          exp;
    } col_row_t;

    logic clk;
    logic rst_n;

    gfr_col_if col_bus ();
    gfr_gap_if gap_bus ();
    gfr_cfg_if cfg_bus ();

    free_run_gap_finder_top_n dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .col_in  (col_bus),
        .gap_out (gap_bus),
        .cfg     (cfg_bus)
    );

    // Register mirror and frame state of the gap list model
    logic [THR_W-1:0]  mirror_thr;
    logic [TOPC_W-1:0] mirror_topc;
    logic [COL_W-1:0]  col_idx;
    bit                run_open;
    logic [COL_W-1:0]  run_first;
    bit                frame_full;
    gap_t              best_gaps [TOP_N_MAX];
    gap_beat_t         frame_gaps [$];
    gap_beat_t         expected_gaps [$];

    int        mismatches;
    int        idle_pct;
    int        hold_requests;
    int        hold_served;
    int        hold_left;
    col_row_t  directed_rows [13];

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #200_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [LEN_W-1:0] span_len(logic [COL_W-1:0] s, logic [COL_W-1:0] e);
        return LEN_W'(e) - LEN_W'(s) + LEN_W'(1);
    endfunction

    function automatic void clear_frame_state();
        col_idx    = '0;
        run_open   = 1'b0;
        run_first  = '0;
        frame_full = 1'b0;
        foreach (best_gaps[k])
            best_gaps[k] = '0;
    endfunction

    // Close the open run at column e; runs of two or more go into the sorted list
    function automatic void insert_run(logic [COL_W-1:0] e);
        logic [LEN_W-1:0] len;
        int pos;
        run_open = 1'b0;
        if (e <= run_first)
            return;
        len = span_len(run_first, e);
        pos = 0;
        // equal length keeps the older run ahead
        for (int k = 0; k < TOP_N_MAX; k++)
            if (best_gaps[k].valid && span_len(best_gaps[k].gap_start, best_gaps[k].gap_end) >= len)
                pos = k + 1;
        if (pos >= TOP_N_MAX)
            return;
        for (int k = TOP_N_MAX - 1; k > pos; k--)
            best_gaps[k] = best_gaps[k - 1];
        best_gaps[pos] = '{1'b1, run_first, e};
    endfunction

    // Advance the model by one column beat; result beats land in frame_gaps
    function automatic void take_column(logic [DEPTH_W-1:0] d, bit last);
        logic [DEPTH_W:0] limit;
        bit free_col;
        int want;
        int held;
        limit    = {1'b0, mirror_thr, 4'b0};
        free_col = !frame_full && d != '0 && {1'b0, d} <= limit;
        if (free_col)
        begin
            if (!run_open)
            begin
                run_open  = 1'b1;
                run_first = col_idx;
            end
        end
        else if (run_open)
            insert_run(frame_full ? col_idx : col_idx - 1'b1);

        if (!last)
        begin
            // past the last column slot the frame is full and the index sticks
            if (col_idx == COL_W'(MAX_COLUMNS - 1))
                frame_full = 1'b1;
            else
                col_idx = col_idx + 1'b1;
            return;
        end

        if (run_open)
            insert_run(col_idx);
        if (mirror_topc == '0)
            want = 1;
        else if (mirror_topc > TOP_N_MAX)
            want = TOP_N_MAX;
        else
            want = mirror_topc;
        held = 0;
        foreach (best_gaps[k])
            if (best_gaps[k].valid)
                held++;
        if (held < want)
            want = held;

        if (want == 0)
            frame_gaps.insert(frame_gaps.size(), NO_GAP);
        else
            for (int k = 0; k < want; k++)
                frame_gaps.insert(frame_gaps.size(),
                                  '{1'b1, RANK_W'(k), best_gaps[k].gap_start,
                                    best_gaps[k].gap_end,
                                    span_len(best_gaps[k].gap_start, best_gaps[k].gap_end),
                                    k == want - 1});
        clear_frame_state();
    endfunction

    // Depth for one column: free values up to and at the limit, zero, above the limit, noise
    function automatic logic [DEPTH_W-1:0] pick_depth(bit want_free);
        logic [DEPTH_W:0] limit;
        limit = {1'b0, mirror_thr, 4'b0};
        if (want_free && limit != '0 && $urandom_range(9) != 0)
        begin
            if ($urandom_range(7) == 0)
                return DEPTH_W'(limit);
            return DEPTH_W'($urandom_range(1, limit));
        end
        case ($urandom_range(2))
            0: return '0;
            1:
            begin
                if (limit < DEPTH_MAX)
                    return DEPTH_W'($urandom_range(limit + 1, DEPTH_MAX));
            end
            default: ;
        endcase
        return DEPTH_W'($urandom);
    endfunction

    // Drive one column beat, wait for the handshake, then queue what it should produce
    task automatic send_column(logic [DEPTH_W-1:0] d, bit last, bit typed, gap_beat_t fixed);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            col_bus.valid <= 1'b0;
            @(negedge clk);
        end
        col_bus.valid       <= 1'b1;
        col_bus.depth_value <= d;
        col_bus.last_column <= last;
        @(posedge clk);
        while (!col_bus.ready)
            @(posedge clk);
        take_column(d, last);
        if (typed)
            expected_gaps.insert(expected_gaps.size(), fixed);
        else
            foreach (frame_gaps[k])
                expected_gaps.insert(expected_gaps.size(), frame_gaps[k]);
        frame_gaps.delete();
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= d;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        if (idx == REG_DEPTH_THRESHOLD)
            mirror_thr = d;
        else if (idx == REG_TOP_COUNT)
            mirror_topc = d[TOPC_W-1:0];
    endtask

    // Stop sending, let every queued gap beat arrive, then give the block time to settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        @(negedge clk);
        col_bus.valid <= 1'b0;
        while (expected_gaps.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random frames built from free / blocked stretches; mostly short, now and then long
    task automatic random_frames(int n_items);
        int sent;
        int frame_len;
        int seg_left;
        bit seg_free;
        sent = 0;
        while (sent < n_items)
        begin
            frame_len = ($urandom_range(9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 16);
            // last frame of the batch is trimmed to the item budget
            if (frame_len > n_items - sent)
                frame_len = n_items - sent;
            seg_left  = 0;
            seg_free  = 1'b0;
            for (int c = 0; c < frame_len; c++)
            begin
                if (seg_left == 0)
                begin
                    seg_free = $urandom_range(99) < 60;
                    seg_left = $urandom_range(1, 6);
                end
                seg_left--;
                send_column(pick_depth(seg_free), c == frame_len - 1, 1'b0, NO_GAP);
            end
            sent += frame_len;
        end
    endtask

    function automatic void check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp_v, act_v);
        end
    endfunction

    // Result monitor: each accepted gap beat against the oldest expectation
    always @(posedge clk)
    begin : gap_monitor
        gap_beat_t got;
        gap_beat_t want;
        if (rst_n && gap_bus.valid === 1'b1 && gap_bus.ready === 1'b1)
        begin
            got = '{gap_bus.found, gap_bus.rank, gap_bus.gap_start, gap_bus.gap_end,
                    gap_bus.gap_length, gap_bus.last_result};
            if (expected_gaps.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected gap beat, expected none, got %h", $time, got);
            end
            else
            begin
                want = expected_gaps.pop_front();
                check_field("found", 32'(want.found), 32'(got.found));
                check_field("rank", 32'(want.rank), 32'(got.rank));
                check_field("gap_start", 32'(want.gap_start), 32'(got.gap_start));
                check_field("gap_end", 32'(want.gap_end), 32'(got.gap_end));
                check_field("gap_length", 32'(want.gap_length), 32'(got.gap_length));
                check_field("last_result", 32'(want.last_result), 32'(got.last_result));
            end
        end
    end

    // Result receiver: random back-pressure plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            gap_bus.ready <= 1'b0;
        end
        else
            gap_bus.ready <= ($urandom_range(99) >= idle_pct);
    end

    initial
    begin
        col_bus.valid       = 1'b0;
        col_bus.depth_value = '0;
        col_bus.last_column = 1'b0;
        gap_bus.ready       = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_DEPTH_THRESHOLD;
        cfg_bus.data        = '0;
        rst_n               = 1'b0;
        mismatches          = 0;
        idle_pct            = IDLE_PCT;
        hold_requests       = 0;
        hold_served         = 0;
        hold_left           = 0;
        mirror_thr          = THRESHOLD_RESET;
        mirror_topc         = TOP_COUNT_RESET;
        clear_frame_state();

        // Reset settings: free columns are 1 .. 2999*16 = 47984, two gaps per frame
        directed_rows = '{
            // single blocked column: no gap
            '{20'd0, 1'b1, 1, 1'b1, NO_GAP},
            // single free column: run of one is dropped
            '{20'd1, 1'b1, 1, 1'b1, NO_GAP},
            // limit is free, one above is not; run 2..4 closed by the last column
            '{20'd47984, 1'b0, 1, 1'b0, NO_GAP},
            '{20'd47985, 1'b0, 1, 1'b0, NO_GAP},
            '{20'd1, 1'b0, 2, 1'b0, NO_GAP},
            '{20'd1, 1'b1, 1, 1'b1, '{1'b1, 3'd0, 10'd2, 10'd4, 11'd3, 1'b1}},
            // three gaps, two of equal length, only two reported
            '{DEPTH_MAX, 1'b0, 1, 1'b0, NO_GAP},
            '{20'd100, 1'b0, 2, 1'b0, NO_GAP},
            '{20'd0, 1'b0, 1, 1'b0, NO_GAP},
            '{20'd200, 1'b0, 3, 1'b0, NO_GAP},
            '{20'd0, 1'b0, 1, 1'b0, NO_GAP},
            '{20'd300, 1'b0, 2, 1'b0, NO_GAP},
            '{20'd0, 1'b1, 1, 1'b0, NO_GAP}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            for (int r = 0; r < directed_rows[i].reps; r++)
                send_column(directed_rows[i].depth,
                            directed_rows[i].last && r == directed_rows[i].reps - 1,
                            directed_rows[i].typed, directed_rows[i].exp);
        wait_idle();

        // Zero threshold: nothing is free
        write_reg(REG_DEPTH_THRESHOLD, 16'd0);
        write_reg(REG_TOP_COUNT, 16'd1);
        random_frames(30);
        wait_idle();

        // Widest threshold, full list, no idling on either side
        write_reg(REG_DEPTH_THRESHOLD, 16'hFFFF);
        write_reg(REG_TOP_COUNT, 16'd8);
        idle_pct = 0;
        random_frames(45);
        wait_idle();
        idle_pct = IDLE_PCT;

        // Top count of zero acts as one; upper data bits are dropped
        write_reg(REG_DEPTH_THRESHOLD, CFG_DATA_W'($urandom_range(1, 200)));
        write_reg(REG_TOP_COUNT, {12'hA5C, 4'd0});
        random_frames(40);
        wait_idle();

        // Oversized top count; receiver holds off so the block backs up
        write_reg(REG_DEPTH_THRESHOLD, 16'd3000);
        write_reg(REG_TOP_COUNT, 16'd15);
        hold_requests++;
        random_frames(50);
        wait_idle();

        // Unmapped index, then random settings
        write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
        write_reg(REG_DEPTH_THRESHOLD, CFG_DATA_W'($urandom));
        write_reg(REG_TOP_COUNT, CFG_DATA_W'($urandom_range(1, 8)));
        random_frames(45);
        wait_idle();

        // Smallest nonzero threshold
        write_reg(REG_DEPTH_THRESHOLD, 16'd1);
        write_reg(REG_TOP_COUNT, 16'd3);
        random_frames(25);
        wait_idle();

        if (expected_gaps.size() != 0)
        begin
            mismatches += expected_gaps.size();
            $display("%0t: %0d gap beats expected but never seen", $time, expected_gaps.size());
        end
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
